// File: rtl/wpia_pkg.sv
// Package for the width-parametric integer ALU.
// Holds the item types, operation and status codes, and the divider side tag.
// No dependencies.
package wpia_pkg;

	localparam logic [4:0] FN_ADD  = 5'd0;
	localparam logic [4:0] FN_SUB  = 5'd1;
	localparam logic [4:0] FN_MUL  = 5'd2;
	localparam logic [4:0] FN_DIV  = 5'd3;
	localparam logic [4:0] FN_MOD  = 5'd4;
	localparam logic [4:0] FN_SHL  = 5'd5;
	localparam logic [4:0] FN_SHR  = 5'd6;
	localparam logic [4:0] FN_AND  = 5'd7;
	localparam logic [4:0] FN_OR   = 5'd8;
	localparam logic [4:0] FN_XOR  = 5'd9;
	localparam logic [4:0] FN_EQ   = 5'd10;
	localparam logic [4:0] FN_NEQ  = 5'd11;
	localparam logic [4:0] FN_LT   = 5'd12;
	localparam logic [4:0] FN_GT   = 5'd13;
	localparam logic [4:0] FN_LTE  = 5'd14;
	localparam logic [4:0] FN_GTE  = 5'd15;
	localparam logic [4:0] FN_NEG  = 5'd16;
	localparam logic [4:0] FN_PLUS = 5'd17;
	localparam logic [4:0] FN_BNOT = 5'd18;
	localparam logic [4:0] FN_LAND = 5'd19;
	localparam logic [4:0] FN_LOR  = 5'd20;
	localparam logic [4:0] FN_LNOT = 5'd21;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DIV_ZERO = 3'd1;
	localparam logic [2:0] ST_DIV_OVF  = 3'd2;
	localparam logic [2:0] ST_SHIFT    = 3'd3;
	localparam logic [2:0] ST_UNSUP    = 3'd4;

	typedef struct packed {
		logic [4:0]  func;
		logic [6:0]  operand_width;
		logic        signed_op;
		logic [63:0] left_value;
		logic [63:0] right_value;
	} alu_in_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic [2:0]  status;
	} alu_out_t;

	// side data that rides alongside the divider
	typedef struct packed {
		logic        is_div;
		logic        is_mod;
		logic        neg_q;
		logic        neg_r;
		logic [63:0] mask;
		logic [63:0] res;
		logic [2:0]  st;
	} wpia_tag_t;

endpackage

// File: rtl/wpia_div.sv
// Pipelined restoring divider, one quotient bit per stage, W stages.
// Carries a wpia_tag_t alongside each item. Depends on wpia_pkg.
module wpia_div #(
	parameter int W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [W-1:0]      num,
	input  logic [W-1:0]      den,
	input  wpia_pkg::wpia_tag_t in_tag,
	output logic              out_valid,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem,
	output wpia_pkg::wpia_tag_t out_tag
);
	import wpia_pkg::*;

	logic              vld_s [W];
	logic [W-1:0]      rem_s [W];
	logic [W-1:0]      num_s [W];
	logic [W-1:0]      den_s [W];
	logic [W-1:0]      quo_s [W];
	wpia_tag_t         tag_s [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W-1:0] rem_in, num_in, den_in, quo_in;
		logic         vld_in;
		wpia_tag_t    tag_in;
		logic [W:0]   trial;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign vld_in = in_valid;
			assign tag_in = in_tag;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign vld_in = vld_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		assign trial = {rem_in, num_in[W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
			num_s[k] <= num_in << 1;
			den_s[k] <= den_in;
			quo_s[k] <= {quo_in[W-2:0], ge};
			tag_s[k] <= tag_in;
		end
	end

	assign out_valid = vld_s[W-1];
	assign quot      = quo_s[W-1];
	assign rem       = rem_s[W-1];
	assign out_tag   = tag_s[W-1];

endmodule

// File: rtl/width_parametric_integer_alu.sv
// Top level of the width-parametric integer ALU.
// Decode, multiply and simple operations in three stages, then wpia_div.
// Depends on wpia_pkg and wpia_div.
//
//  channel   ports               handshake
//  input     start, busy, op     taken when start && !busy
//  result    done, res           one cycle wide strobe on done
//
// Each item passes stages 1 to 3, the wpia_div stages and the output stage
// on its way from start to done; one item may enter in every cycle.
// busy is always low: no stage ever waits, as the receiver cannot stall.
// Reset clears the valid bits only; payload stages are not reset.
module width_parametric_integer_alu #(
	parameter int DATA_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  wpia_pkg::alu_in_t op,
	output logic              done,
	output wpia_pkg::alu_out_t res
);
	import wpia_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int LAT = DATA_WIDTH + 4;

	// stage 1: clamp width, mask operands
	logic [6:0]  weff;
	logic [63:0] mask_c;

	logic        vld_s1, sgn_s1, lnz_s1, rnz_s1, na_s1, nb_s1;
	logic [4:0]  func_s1;
	logic [6:0]  w_s1;
	logic [63:0] mask_s1, msb_s1, l_s1, r_s1, ls_s1, rs_s1;

	always_comb begin
		if (op.operand_width == 7'd0) begin
			weff = 7'd1;
		end else if (op.operand_width > 7'(DATA_WIDTH)) begin
			weff = 7'(DATA_WIDTH);
		end else begin
			weff = op.operand_width;
		end
		mask_c = ~({64{1'b1}} << weff);
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] l, r, msb;
		logic        na, nb;
		l   = op.left_value & mask_c;
		r   = op.right_value & mask_c;
		msb = mask_c ^ (mask_c >> 1);
		na  = op.signed_op & (|(l & msb));
		nb  = op.signed_op & (|(r & msb));
		func_s1 <= op.func;
		w_s1    <= weff;
		sgn_s1  <= op.signed_op;
		mask_s1 <= mask_c;
		msb_s1  <= msb;
		l_s1    <= l;
		r_s1    <= r;
		na_s1   <= na;
		nb_s1   <= nb;
		ls_s1   <= na ? (l | ~mask_c) : l;
		rs_s1   <= nb ? (r | ~mask_c) : r;
		lnz_s1  <= |op.left_value;
		rnz_s1  <= |op.right_value;
	end

	// stage 2: simple operations, status, partial products, magnitudes
	logic        vld_s2, is_div_s2, is_mod_s2, nq_s2, nr_s2, mul_s2;
	logic [2:0]  st_s2;
	logic [63:0] simp_s2, mask_s2, p00_s2;
	logic [31:0] p01_s2, p10_s2;
	logic [W-1:0] ua_s2, ub_s2;

	logic [63:0] ka, kb, simp_c, shr_c;
	logic [2:0]  st_c;
	logic        shift_bad;

	always_comb begin
		ka = ls_s1 ^ {sgn_s1, 63'd0};
		kb = rs_s1 ^ {sgn_s1, 63'd0};
		shift_bad = r_s1 >= {57'd0, w_s1};
		shr_c = sgn_s1 ? 64'($signed(ls_s1) >>> r_s1[5:0]) : (l_s1 >> r_s1[5:0]);
		st_c   = ST_OK;
		simp_c = '0;
		case (func_s1)
			FN_ADD:  simp_c = (l_s1 + r_s1) & mask_s1;
			FN_SUB:  simp_c = (l_s1 - r_s1) & mask_s1;
			FN_MUL:  simp_c = '0;
			FN_DIV, FN_MOD: begin
				if (r_s1 == '0) begin
					st_c = ST_DIV_ZERO;
				end else if (sgn_s1 && l_s1 == msb_s1 && r_s1 == mask_s1) begin
					st_c = ST_DIV_OVF;
				end
			end
			FN_SHL, FN_SHR: begin
				if (shift_bad) begin
					st_c = ST_SHIFT;
				end else if (func_s1 == FN_SHL) begin
					simp_c = (l_s1 << r_s1[5:0]) & mask_s1;
				end else begin
					simp_c = shr_c & mask_s1;
				end
			end
			FN_AND:  simp_c = l_s1 & r_s1;
			FN_OR:   simp_c = l_s1 | r_s1;
			FN_XOR:  simp_c = l_s1 ^ r_s1;
			FN_EQ:   simp_c = {63'd0, l_s1 == r_s1};
			FN_NEQ:  simp_c = {63'd0, l_s1 != r_s1};
			FN_LT:   simp_c = {63'd0, ka < kb};
			FN_GT:   simp_c = {63'd0, ka > kb};
			FN_LTE:  simp_c = {63'd0, ka <= kb};
			FN_GTE:  simp_c = {63'd0, ka >= kb};
			FN_NEG:  simp_c = (64'd0 - l_s1) & mask_s1;
			FN_PLUS: simp_c = l_s1;
			FN_BNOT: simp_c = ~l_s1 & mask_s1;
			FN_LAND: simp_c = {63'd0, lnz_s1 && rnz_s1};
			FN_LOR:  simp_c = {63'd0, lnz_s1 || rnz_s1};
			FN_LNOT: simp_c = {63'd0, !lnz_s1};
			default: st_c = ST_UNSUP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		simp_s2   <= simp_c;
		st_s2     <= st_c;
		mask_s2   <= mask_s1;
		is_div_s2 <= func_s1 == FN_DIV;
		is_mod_s2 <= func_s1 == FN_MOD;
		mul_s2    <= func_s1 == FN_MUL;
		nq_s2     <= na_s1 ^ nb_s1;
		nr_s2     <= na_s1;
		p00_s2    <= 64'(l_s1[31:0] * r_s1[31:0]);
		p01_s2    <= 32'(l_s1[31:0] * r_s1[63:32]);
		p10_s2    <= 32'(l_s1[63:32] * r_s1[31:0]);
		ua_s2     <= W'(na_s1 ? (64'd0 - ls_s1) : l_s1);
		ub_s2     <= W'(nb_s1 ? (64'd0 - rs_s1) : r_s1);
	end

	// stage 3: sum the product, build the tag
	logic         vld_s3;
	logic [W-1:0] ua_s3, ub_s3;
	wpia_tag_t    tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] prod;
		prod = p00_s2 + {p01_s2 + p10_s2, 32'd0};
		ua_s3         <= ua_s2;
		ub_s3         <= ub_s2;
		tag_s3.is_div <= is_div_s2;
		tag_s3.is_mod <= is_mod_s2;
		tag_s3.neg_q  <= nq_s2;
		tag_s3.neg_r  <= nr_s2;
		tag_s3.mask   <= mask_s2;
		tag_s3.st     <= st_s2;
		tag_s3.res    <= (st_s2 != ST_OK) ? 64'd0 :
			mul_s2 ? (prod & mask_s2) : simp_s2;
	end

	// divider stages
	logic         dv_vld;
	logic [W-1:0] dv_q, dv_r;
	wpia_tag_t    dv_tag;

	wpia_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.num      (ua_s3),
		.den      (ub_s3),
		.in_tag   (tag_s3),
		.out_valid(dv_vld),
		.quot     (dv_q),
		.rem      (dv_r),
		.out_tag  (dv_tag)
	);

	// output stage: apply signs and pick
	logic     done_s;
	alu_out_t res_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s <= 1'b0;
		end else begin
			done_s <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] q, m;
		q = {{(64-W){1'b0}}, dv_q};
		m = {{(64-W){1'b0}}, dv_r};
		if (dv_tag.neg_q) q = 64'd0 - q;
		if (dv_tag.neg_r) m = 64'd0 - m;
		res_s.status <= dv_tag.st;
		if (dv_tag.st != ST_OK) begin
			res_s.result_value <= '0;
		end else if (dv_tag.is_div) begin
			res_s.result_value <= q & dv_tag.mask;
		end else if (dv_tag.is_mod) begin
			res_s.result_value <= m & dv_tag.mask;
		end else begin
			res_s.result_value <= dv_tag.res;
		end
	end

	assign done = done_s;
	assign res  = res_s;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("item lost in pipeline");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status != ST_OK |-> res.result_value == 64'd0)
		else $error("nonzero result with error status");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.status <= ST_UNSUP) else $error("bad status code");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for width_parametric_integer_alu: a directed table, then random items.
// Results are checked in order against the table's expected values or a behavioural ALU model kept in this file.
// Depends on wpia_pkg and the ALU RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import wpia_pkg::*;

	localparam int          ALU_WIDTH  = 64;
	localparam int          PIPE_DEPTH = ALU_WIDTH + 4;
	localparam logic [4:0]  FN_BAD_LO  = 5'd22;
	localparam logic [4:0]  FN_BAD_HI  = 5'd31;
	localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		alu_in_t  stim;
		bit       known;
		alu_out_t want;
	} alu_row_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	alu_in_t  op;
	logic     done;
	alu_out_t res;

	alu_out_t pending_results[$];
	alu_row_t dir_rows[$];
	int       fail_count;

	width_parametric_integer_alu #(.DATA_WIDTH(ALU_WIDTH)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .done(done), .res(res)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [63:0] width_mask(int unsigned w);
		return (w >= 64) ? ALL_ONES : ((64'd1 << w) - 64'd1);
	endfunction

	function automatic logic [63:0] sign_extend(logic [63:0] v, int unsigned w);
		if (w >= 64)
			return v;
		return v[w-1] ? (v | ~width_mask(w)) : v;
	endfunction

	function automatic alu_out_t alu_predict(alu_in_t x);
		int unsigned w;
		logic [63:0] m, l, r, val, ka, kb, ua, ub, q, rem, minv;
		logic [2:0]  st;
		bit          na, nb;
		alu_out_t    o;
		w = x.operand_width;
		if (w < 1) w = 1;
		if (w > ALU_WIDTH) w = ALU_WIDTH;
		m = width_mask(w);
		l = x.left_value & m;
		r = x.right_value & m;
		ka = x.signed_op ? (sign_extend(l, w) ^ (64'd1 << 63)) : l;
		kb = x.signed_op ? (sign_extend(r, w) ^ (64'd1 << 63)) : r;
		val = '0;
		st = ST_OK;
		case (x.func)
			FN_ADD: val = (l + r) & m;
			FN_SUB: val = (l - r) & m;
			FN_MUL: val = (l * r) & m;
			FN_DIV, FN_MOD: begin
				minv = 64'd1 << (w - 1);
				if (r == 0)
					st = ST_DIV_ZERO;
				else if (x.signed_op && l == minv && r == m)
					st = ST_DIV_OVF;
				else if (x.signed_op) begin
					na = l[w-1];
					nb = r[w-1];
					ua = na ? -sign_extend(l, w) : l;
					ub = nb ? -sign_extend(r, w) : r;
					q = ua / ub;
					rem = ua % ub;
					if (na != nb) q = -q;
					if (na) rem = -rem;
					val = ((x.func == FN_DIV) ? q : rem) & m;
				end else
					val = (x.func == FN_DIV) ? l / r : l % r;
			end
			FN_SHL, FN_SHR: begin
				if (r >= 64'(w))
					st = ST_SHIFT;
				else if (x.func == FN_SHL)
					val = (l << r) & m;
				else if (!x.signed_op)
					val = l >> r;
				else
					val = 64'($signed(sign_extend(l, w)) >>> r) & m;
			end
			FN_AND:  val = l & r;
			FN_OR:   val = l | r;
			FN_XOR:  val = l ^ r;
			FN_EQ:   val = 64'(l == r);
			FN_NEQ:  val = 64'(l != r);
			FN_LT:   val = 64'(ka < kb);
			FN_GT:   val = 64'(ka > kb);
			FN_LTE:  val = 64'(ka <= kb);
			FN_GTE:  val = 64'(ka >= kb);
			FN_NEG:  val = (-l) & m;
			FN_PLUS: val = l;
			FN_BNOT: val = ~l & m;
			FN_LAND: val = 64'(x.left_value != 0 && x.right_value != 0);
			FN_LOR:  val = 64'(x.left_value != 0 || x.right_value != 0);
			FN_LNOT: val = 64'(x.left_value == 0);
			default: st = ST_UNSUP;
		endcase
		if (st != ST_OK) val = '0;
		o.result_value = val;
		o.status = st;
		return o;
	endfunction

	task automatic add_row(logic [4:0] f, logic [6:0] w, logic s, logic [63:0] l,
			logic [63:0] r, bit known = 0, logic [63:0] v = 0, logic [2:0] st = ST_OK);
		alu_row_t row;
		row.stim.func = f;
		row.stim.operand_width = w;
		row.stim.signed_op = s;
		row.stim.left_value = l;
		row.stim.right_value = r;
		row.known = known;
		row.want.result_value = v;
		row.want.status = st;
		dir_rows.push_back(row);
	endtask

	// pick operands that favour edge values of the chosen width
	function automatic logic [63:0] pick_operand(int unsigned w);
		logic [63:0] m, v;
		int unsigned ww;
		ww = (w < 1) ? 1 : (w > 64 ? 64 : w);
		m = width_mask(ww);
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = 64'd0;
			1: v = 64'd1;
			2: v = m;
			3: v = 64'd1 << (ww - 1);
			4: v = 64'($urandom_range(0, 70));
			5: v = {$urandom, $urandom};
			default: v = v & m;
		endcase
		return v;
	endfunction

	function automatic alu_in_t random_item();
		alu_in_t x;
		x.func = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 21));
		case ($urandom_range(0, 5))
			0: x.operand_width = 7'd64;
			1: x.operand_width = 7'd1;
			2: x.operand_width = 7'($urandom_range(0, 127));
			3: x.operand_width = 7'($urandom_range(1, 8));
			default: x.operand_width = 7'($urandom_range(1, 64));
		endcase
		x.signed_op = 1'($urandom_range(0, 1));
		x.left_value = pick_operand(x.operand_width);
		x.right_value = pick_operand(x.operand_width);
		// steer some divides onto the minimum by minus one case
		if ((x.func == FN_DIV || x.func == FN_MOD) && $urandom_range(0, 5) == 0) begin
			x.signed_op = 1'b1;
			x.left_value = 64'd1 << ((x.operand_width < 1 ? 1
				: (x.operand_width > 64 ? 64 : x.operand_width)) - 1);
			x.right_value = ALL_ONES;
		end
		return x;
	endfunction

	// hold start and op from the falling edge until the item is taken
	task automatic send_item(alu_in_t x, alu_out_t want, int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op <= x;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pending_results.push_back(want);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		alu_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%t: result with none pending: value %h status %0d",
					$realtime, res.result_value, res.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (res.result_value !== want.result_value) begin
					$display("%t: result_value expected %h actual %h",
						$realtime, want.result_value, res.result_value);
					fail_count++;
				end
				if (res.status !== want.status) begin
					$display("%t: status expected %0d actual %0d",
						$realtime, want.status, res.status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		alu_in_t     x;
		int unsigned gap;
		bit          idle_on;
		int          wait_cycles;
		fail_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = '0;

		add_row(FN_ADD, 7'd64, 1'b0, ALL_ONES, 64'd1, 1, 64'd0, ST_OK);
		add_row(FN_SUB, 7'd8, 1'b0, 64'd0, 64'd1, 1, 64'hFF, ST_OK);
		add_row(FN_MUL, 7'd64, 1'b1, ALL_ONES, 64'h8000_0000_0000_0000);
		add_row(FN_DIV, 7'd16, 1'b0, 64'd1234, 64'd0, 1, 64'd0, ST_DIV_ZERO);
		add_row(FN_MOD, 7'd64, 1'b1, 64'd5, 64'd0, 1, 64'd0, ST_DIV_ZERO);
		add_row(FN_DIV, 7'd8, 1'b1, 64'h80, 64'hFF, 1, 64'd0, ST_DIV_OVF);
		add_row(FN_MOD, 7'd64, 1'b1, 64'h8000_0000_0000_0000, ALL_ONES, 1, 64'd0, ST_DIV_OVF);
		add_row(FN_DIV, 7'd1, 1'b1, 64'd1, 64'd1, 1, 64'd0, ST_DIV_OVF);
		add_row(FN_DIV, 7'd8, 1'b1, 64'hF9, 64'd2);
		add_row(FN_MOD, 7'd8, 1'b1, 64'hF9, 64'd2);
		add_row(FN_SHL, 7'd8, 1'b0, 64'd1, 64'd8, 1, 64'd0, ST_SHIFT);
		add_row(FN_SHR, 7'd8, 1'b1, 64'h90, 64'hFF, 1, 64'd0, ST_SHIFT);
		add_row(FN_SHR, 7'd8, 1'b1, 64'h90, 64'd3);
		add_row(FN_SHL, 7'd64, 1'b0, 64'd1, 64'd63);
		add_row(FN_AND, 7'd0, 1'b0, ALL_ONES, ALL_ONES, 1, 64'd1, ST_OK);
		add_row(FN_OR, 7'd127, 1'b0, 64'hF0F0, 64'h0F0F);
		add_row(FN_XOR, 7'd32, 1'b0, ALL_ONES, 64'h1234_5678);
		add_row(FN_EQ, 7'd4, 1'b0, 64'h13, 64'h03, 1, 64'd1, ST_OK);
		add_row(FN_NEQ, 7'd64, 1'b0, 64'd7, 64'd7, 1, 64'd0, ST_OK);
		add_row(FN_LT, 7'd8, 1'b1, 64'h80, 64'h7F, 1, 64'd1, ST_OK);
		add_row(FN_GT, 7'd8, 1'b0, 64'h80, 64'h7F, 1, 64'd1, ST_OK);
		add_row(FN_LTE, 7'd64, 1'b1, ALL_ONES, 64'd0);
		add_row(FN_GTE, 7'd64, 1'b0, ALL_ONES, 64'd0);
		add_row(FN_NEG, 7'd8, 1'b1, 64'h80, 64'd0, 1, 64'h80, ST_OK);
		add_row(FN_PLUS, 7'd12, 1'b0, ALL_ONES, 64'd0, 1, 64'hFFF, ST_OK);
		add_row(FN_BNOT, 7'd16, 1'b0, 64'h00FF, 64'd0, 1, 64'hFF00, ST_OK);
		add_row(FN_LAND, 7'd1, 1'b0, 64'h100, 64'h2, 1, 64'd1, ST_OK);
		add_row(FN_LOR, 7'd8, 1'b0, 64'd0, 64'h100, 1, 64'd1, ST_OK);
		add_row(FN_LNOT, 7'd8, 1'b0, 64'h100, 64'd0, 1, 64'd0, ST_OK);
		add_row(FN_BAD_LO, 7'd8, 1'b0, 64'd1, 64'd1, 1, 64'd0, ST_UNSUP);
		add_row(FN_BAD_HI, 7'd64, 1'b1, ALL_ONES, ALL_ONES, 1, 64'd0, ST_UNSUP);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].stim,
				dir_rows[i].known ? dir_rows[i].want : alu_predict(dir_rows[i].stim),
				$urandom_range(0, 2));

		idle_on = 1'b0;
		for (int n = 0; n < 650; n++) begin
			if (n % 50 == 0) idle_on = ~idle_on;
			// drain the pipeline once mid-run
			if (n == 325) begin
				start <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
			end
			gap = idle_on ? $urandom_range(0, 5) : 0;
			x = random_item();
			send_item(x, alu_predict(x), gap);
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 20 * PIPE_DEPTH) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
